/* rtl/pulse_frame_sync_capture_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pulse frame sync capture unit
// Shared concurrent-check helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PULSE_FRAME_SYNC_CAPTURE_UNIT_DEFINES_SVH
`define PULSE_FRAME_SYNC_CAPTURE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PFSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pfsc_pkg.sv */
// ----------------------------------------------------------------------------
// pfsc_pkg
// Types, register indexes and constants of the pulse frame sync capture unit.
// ----------------------------------------------------------------------------
package pfsc_pkg;

  localparam int StampW   = 16;
  localparam int SlotW    = 5;
  localparam int PctW     = 7;
  localparam int SettleW  = 7;
  localparam int ProdW    = StampW + PctW;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  localparam int SlotsDefault = 32;

  localparam logic [ProdW-1:0]    PctScale          = ProdW'(100);
  localparam logic [PctW-1:0]     DropPercentReset  = PctW'(40);
  localparam logic [SettleW-1:0]  SettleCountReset  = SettleW'(100);
  localparam logic [SlotW-1:0]    FrameLengthReset  = SlotW'(6);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DROP_PERCENT = 2'd0,
    REG_SETTLE_COUNT = 2'd1,
    REG_FRAME_LENGTH = 2'd2
  } pfsc_reg_e;

  typedef enum logic {
    EDGE_RISE = 1'b0,
    EDGE_FALL = 1'b1
  } pfsc_edge_e;

  typedef struct packed {
    logic              mode;
    logic [StampW-1:0] stamp;
  } pfsc_in_t;

  typedef struct packed {
    logic [StampW-1:0] meas_width;
    logic [SlotW-1:0]  slot_written;
    logic [SlotW-1:0]  channel;
    logic              resync;
    logic              frame_done;
    logic              sample_gate;
  } pfsc_out_t;

  typedef struct packed {
    logic [PctW-1:0]    drop_percent;
    logic [SettleW-1:0] settle_count;
    logic [SlotW-1:0]   frame_length;
  } pfsc_cfg_t;

endpackage

/* rtl/pfsc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pfsc_cfg_regs
// Configuration register file: drop percent, settle count, frame length.
// ----------------------------------------------------------------------------
module pfsc_cfg_regs
  import pfsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output pfsc_cfg_t           cfg_o
);

  pfsc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drop_percent <= DropPercentReset;
      cfg_q.settle_count <= SettleCountReset;
      cfg_q.frame_length <= FrameLengthReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DROP_PERCENT: cfg_q.drop_percent <= cfg_data_i[PctW-1:0];
        REG_SETTLE_COUNT: cfg_q.settle_count <= cfg_data_i[SettleW-1:0];
        REG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data_i[SlotW-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/pfsc_event.sv */
// ----------------------------------------------------------------------------
// pfsc_event
// Per-event state (fall stamp, previous width, slot, settle counter, gate)
// and the combinational logic that turns one capture event into a result.
// ----------------------------------------------------------------------------
module pfsc_event
  import pfsc_pkg::*;
#(
  parameter int Slots = SlotsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      ev_valid_i,
  input  pfsc_in_t  ev_i,
  input  pfsc_cfg_t cfg_i,
  output pfsc_out_t res_o
);

  localparam int SlotTopInt = (Slots - 1 > 31) ? 31 : Slots - 1;
  localparam logic [SlotW-1:0] SlotTop = SlotW'(SlotTopInt);

  logic [StampW-1:0]  fall_stamp_q, fall_stamp_d;
  logic [StampW-1:0]  prev_width_q, prev_width_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [SettleW-1:0] settle_q, settle_d;
  logic               gate_q, gate_d;

  logic              rising;
  logic              settled;
  logic              drop;
  logic [StampW-1:0] width;
  logic [StampW-1:0] diff;
  logic [ProdW-1:0]  fall_prod;
  logic [ProdW-1:0]  lim_prod;
  logic [SlotW-1:0]  slot_adv;

  always_comb begin
    rising    = (ev_i.mode == EDGE_RISE);
    width     = ev_i.stamp - fall_stamp_q;
    diff      = prev_width_q - width;
    fall_prod = ProdW'(diff) * PctScale;
    lim_prod  = ProdW'(cfg_i.drop_percent) * ProdW'(prev_width_q);
    drop      = (prev_width_q > width) && (fall_prod > lim_prod);
    slot_adv  = (slot_q < SlotTop) ? slot_q + SlotW'(1) : slot_q;

    fall_stamp_d = fall_stamp_q;
    prev_width_d = prev_width_q;
    slot_d       = slot_q;
    settle_d     = settle_q;
    gate_d       = gate_q;

    if (rising) begin
      if (settle_q < cfg_i.settle_count) begin
        settle_d = settle_q + SettleW'(1);
      end
      prev_width_d = width;
      slot_d       = drop ? '0 : slot_adv;
    end else begin
      fall_stamp_d = ev_i.stamp;
    end

    settled = (settle_d >= cfg_i.settle_count);
    if (settled) begin
      gate_d = !rising;
    end

    res_o.meas_width   = rising ? width : '0;
    res_o.slot_written = slot_q;
    res_o.channel      = slot_d;
    res_o.resync       = rising && drop;
    res_o.frame_done   = (slot_d == cfg_i.frame_length);
    res_o.sample_gate  = gate_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_stamp_q <= '0;
      prev_width_q <= '0;
      slot_q       <= '0;
      settle_q     <= '0;
      gate_q       <= 1'b0;
    end else if (ev_valid_i) begin
      fall_stamp_q <= fall_stamp_d;
      prev_width_q <= prev_width_d;
      slot_q       <= slot_d;
      settle_q     <= settle_d;
      gate_q       <= gate_d;
    end
  end

endmodule

/* rtl/pulse_frame_sync_capture_unit.sv */
// ----------------------------------------------------------------------------
// pulse_frame_sync_capture_unit
// Measures pulse widths from timer capture events and tracks frame slots.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_data_i): one capture transaction
//     per timer edge, mode 0 for a rising edge, mode 1 for a falling edge.
//   out channel (out_valid_o/out_ready_i/out_data_o): one result per input
//     transaction, in order: width, slot written, channel, resync, frame
//     done and sample gate level.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): index 0
//     drop percent, 1 settle count, 2 frame length; always ready. Write
//     only while no event is in flight.
// Timing: the accepting edge loads the input register; the result register
// then loads from the event logic (a 7x16 multiply, a multiply by 100 and
// compares against the stored state) once it may advance, and out_valid_o
// rises with that load. Throughput is one event per cycle while the
// receiver does not stall, set by the state update done in that single stage.
// Reset clears all event state and loads the register defaults (40, 100, 6).
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready_o drops until out_ready_i returns.
// ----------------------------------------------------------------------------
`include "pulse_frame_sync_capture_unit_defines.svh"

module pulse_frame_sync_capture_unit
  import pfsc_pkg::*;
#(
  parameter int SLOTS = SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfsc_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfsc_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic      in_valid_q;
  pfsc_in_t  in_q;
  logic      out_valid_q;
  pfsc_out_t out_q;
  logic      advance;
  pfsc_cfg_t cfg;
  pfsc_out_t ev_res;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  pfsc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pfsc_event #(
    .Slots (SLOTS)
  ) u_event (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_valid_i (in_valid_q && advance),
    .ev_i       (in_q),
    .cfg_i      (cfg),
    .res_o      (ev_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance && in_valid_q) begin
      out_q <= ev_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PFSC_ASSERT_IMP(a_resync_zero_slot, out_valid_o && out_data_o.resync,
      out_data_o.channel == '0, "resync result with nonzero channel")
  `PFSC_ASSERT_IMP(a_slot_step, out_valid_o && !out_data_o.resync,
      (out_data_o.channel == out_data_o.slot_written) ||
      (out_data_o.channel == SlotW'(out_data_o.slot_written + SlotW'(1))),
      "slot moved by more than one")
  `PFSC_ASSERT_IMP(a_stall_only_on_full, !in_ready_o,
      in_valid_q && out_valid_o && !out_ready_i, "input stalled without backpressure")
  `PFSC_ASSERT_NXT(a_event_reaches_out, in_valid_q && advance,
      out_valid_o, "buffered event not moved to result register")

endmodule
